### rtl/adsr_pkg.sv
package adsr_pkg;

  localparam int TIME_W  = 32;
  localparam int FRAC    = 15;
  localparam int LVL_W   = FRAC + 1;
  localparam int DUR_W   = 24;
  localparam int CURVE_W = 2;
  localparam int ALU_W   = TIME_W;
  localparam int SQ_W    = 2 * FRAC + 1;
  localparam int MUL_W   = 2 * LVL_W;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DUR_W;

  localparam int DIV_STEPS  = FRAC;
  localparam int SQRT_STEPS = FRAC + 1;

  localparam logic [LVL_W-1:0] ONE_LVL = LVL_W'(1) << FRAC;

  localparam logic [DUR_W-1:0]   RST_ATTACK_TICKS  = 24'd4800;
  localparam logic [DUR_W-1:0]   RST_DECAY_TICKS   = 24'd14400;
  localparam logic [LVL_W-1:0]   RST_SUSTAIN_LEVEL = 16'd22938;
  localparam logic [DUR_W-1:0]   RST_RELEASE_TICKS = 24'd24000;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_CURVE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_CURVE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CURVE = 3'd6;

  localparam logic [CURVE_W-1:0] CRV_LINEAR = 2'd0;
  localparam logic [CURVE_W-1:0] CRV_SQUARE = 2'd1;
  localparam logic [CURVE_W-1:0] CRV_SQRT   = 2'd2;

  typedef enum logic [2:0] {
    ST_ATTACK  = 3'd0,
    ST_DECAY   = 3'd1,
    ST_SUSTAIN = 3'd2,
    ST_RELEASE = 3'd3,
    ST_OFF     = 3'd4
  } stage_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_ELAPSE,
    SQ_CHECK,
    SQ_PHASE,
    SQ_DIV,
    SQ_SHAPE,
    SQ_SQUARE,
    SQ_TAKE,
    SQ_SQRT,
    SQ_SCALE,
    SQ_BLEND,
    SQ_FINISH
  } seq_t;

  typedef struct packed {
    logic [TIME_W-1:0] note_time;
    logic              gate;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    stage_t           stage;
  } out_item_t;

  function automatic logic [DUR_W-1:0] dur_of(input logic [DUR_W-1:0] ticks);
    return (ticks == '0) ? DUR_W'(1) : ticks;
  endfunction

endpackage

### rtl/adsr_envelope_generator.sv
// ADSR envelope generator. Each request carries a note time and a gate and
// returns one result: the envelope level in Q1.15 (32768 is full scale) and
// the stage it belongs to. All work runs through one shared subtractor and
// one 16x16 multiplier under a small sequencer, and in_ready is low while a
// request is in flight. A request that lands in sustain or off passes only
// the elapse, check, phase and finish states. Attack, decay and release add
// curve select and scale states and, below full phase, 15 restoring divide
// steps; a square curve adds square and take states, a square root curve 16
// root steps; decay and release add a blend subtract. The longest path is
// decay or release below full phase on a square root curve, set by the divide
// and root iterations on the shared subtractor; a result may also wait for
// out_ready. Configuration writes are always accepted (cfg_ready is held high)
// and must only be issued while the block is idle.
module adsr_envelope_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  adsr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output adsr_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TW = adsr_pkg::TIME_W;
  localparam int LW = adsr_pkg::LVL_W;
  localparam int DW = adsr_pkg::DUR_W;
  localparam int CW = adsr_pkg::CURVE_W;
  localparam int AW = adsr_pkg::ALU_W;
  localparam int SW = adsr_pkg::SQ_W;
  localparam int MW = adsr_pkg::MUL_W;
  localparam int NW = adsr_pkg::CNT_W;
  localparam int FR = adsr_pkg::FRAC;

  // configuration
  logic [DW-1:0] attack_ticks_r, decay_ticks_r, release_ticks_r;
  logic [LW-1:0] sustain_level_r;
  logic [CW-1:0] attack_curve_r, decay_curve_r, release_curve_r;

  // envelope state
  adsr_pkg::seq_t   seq_r, seq_nxt;
  adsr_pkg::stage_t stage_r, stage_nxt;
  logic [TW-1:0] start_r, start_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [LW-1:0] relf_r, relf_nxt;

  // working registers
  logic [TW-1:0] now_r, now_nxt;
  logic          gate_r, gate_nxt;
  logic [TW-1:0] elapsed_r, elapsed_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [FR-1:0] q_r, q_nxt;
  logic [LW-1:0] t_r, t_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [MW-1:0] prod_r, prod_nxt;
  logic [LW-1:0] c_r, c_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;

  logic                out_valid_r, out_valid_nxt;
  adsr_pkg::out_item_t out_data_r, out_data_nxt;

  // shared unit
  logic [AW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_ge;
  logic [LW-1:0] mul_a, mul_b;
  logic [MW-1:0] mul_prod;

  logic [DW-1:0] dur;
  logic [CW-1:0] curve;
  logic [LW-1:0] sus;
  logic [DW:0]   rem_shift;
  logic [SW:0]   root_try;
  logic          out_free;

  adsr_alu u_alu (
    .sub_a    (alu_a),
    .sub_b    (alu_b),
    .sub_diff (alu_diff),
    .sub_ge   (alu_ge),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_prod (mul_prod)
  );

  assign sus       = (sustain_level_r > adsr_pkg::ONE_LVL) ? adsr_pkg::ONE_LVL
                                                           : sustain_level_r;
  assign rem_shift = {rem_r, 1'b0};
  assign root_try  = {1'b0, res_r} + {1'b0, bit_r};
  assign out_free  = ~out_valid_r | out_ready;

  always_comb begin
    case (stage_r)
      adsr_pkg::ST_ATTACK: begin
        dur   = adsr_pkg::dur_of(attack_ticks_r);
        curve = attack_curve_r;
      end
      adsr_pkg::ST_DECAY: begin
        dur   = adsr_pkg::dur_of(decay_ticks_r);
        curve = decay_curve_r;
      end
      adsr_pkg::ST_RELEASE: begin
        dur   = adsr_pkg::dur_of(release_ticks_r);
        curve = release_curve_r;
      end
      default: begin
        dur   = DW'(1);
        curve = adsr_pkg::CRV_LINEAR;
      end
    endcase
  end

  // datapath next values and shared unit operand selection
  always_comb begin
    stage_nxt     = stage_r;
    start_nxt     = start_r;
    level_nxt     = level_r;
    relf_nxt      = relf_r;
    now_nxt       = now_r;
    gate_nxt      = gate_r;
    elapsed_nxt   = elapsed_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    t_nxt         = t_r;
    cnt_nxt       = cnt_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    prod_nxt      = prod_r;
    c_nxt         = c_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    alu_a         = '0;
    alu_b         = '0;
    mul_a         = t_r;
    mul_b         = t_r;
    case (seq_r)
      adsr_pkg::SQ_IDLE: begin
        if (in_valid) begin
          now_nxt  = in_data.note_time;
          gate_nxt = in_data.gate;
        end
      end
      adsr_pkg::SQ_ELAPSE: begin
        alu_a       = AW'(now_r);
        alu_b       = AW'(start_r);
        // time running backwards saturates at zero
        elapsed_nxt = alu_ge ? TW'(alu_diff) : '0;
      end
      adsr_pkg::SQ_CHECK: begin
        alu_a = AW'(elapsed_r);
        alu_b = AW'(dur);
        case (stage_r)
          adsr_pkg::ST_ATTACK, adsr_pkg::ST_DECAY, adsr_pkg::ST_SUSTAIN: begin
            if (!gate_r) begin
              stage_nxt   = adsr_pkg::ST_RELEASE;
              start_nxt   = now_r;
              relf_nxt    = level_r;
              elapsed_nxt = '0;
            end else if (alu_ge && stage_r == adsr_pkg::ST_ATTACK) begin
              stage_nxt   = adsr_pkg::ST_DECAY;
              start_nxt   = now_r;
              elapsed_nxt = '0;
            end else if (alu_ge && stage_r == adsr_pkg::ST_DECAY) begin
              // sustain keeps the decay start time
              stage_nxt = adsr_pkg::ST_SUSTAIN;
            end
          end
          adsr_pkg::ST_RELEASE: begin
            if (gate_r) begin
              stage_nxt   = adsr_pkg::ST_ATTACK;
              start_nxt   = now_r;
              elapsed_nxt = '0;
            end else if (alu_ge) begin
              stage_nxt = adsr_pkg::ST_OFF;
            end
          end
          default: begin
            stage_nxt = adsr_pkg::ST_OFF;
            if (gate_r) begin
              stage_nxt   = adsr_pkg::ST_ATTACK;
              start_nxt   = now_r;
              elapsed_nxt = '0;
            end
          end
        endcase
      end
      adsr_pkg::SQ_PHASE: begin
        alu_a = AW'(elapsed_r);
        alu_b = AW'(dur);
        case (stage_r)
          adsr_pkg::ST_SUSTAIN: lvl_nxt = sus;
          adsr_pkg::ST_ATTACK, adsr_pkg::ST_DECAY, adsr_pkg::ST_RELEASE: begin
            if (alu_ge) begin
              t_nxt = adsr_pkg::ONE_LVL;
            end else begin
              rem_nxt = elapsed_r[DW-1:0];
              q_nxt   = '0;
              cnt_nxt = '0;
            end
          end
          default: lvl_nxt = '0;
        endcase
      end
      adsr_pkg::SQ_DIV: begin
        alu_a   = AW'(rem_shift);
        alu_b   = AW'(dur);
        rem_nxt = alu_ge ? alu_diff[DW-1:0] : rem_shift[DW-1:0];
        q_nxt   = {q_r[FR-2:0], alu_ge};
        cnt_nxt = cnt_r + NW'(1);
        t_nxt   = {1'b0, q_nxt};
      end
      adsr_pkg::SQ_SHAPE: begin
        c_nxt   = t_r;
        v_nxt   = {t_r, {FR{1'b0}}};
        res_nxt = '0;
        bit_nxt = SW'(1) << (SW - 1);
        cnt_nxt = '0;
      end
      adsr_pkg::SQ_SQUARE: begin
        prod_nxt = mul_prod;
      end
      adsr_pkg::SQ_TAKE: begin
        c_nxt = prod_r[FR+LW-1:FR];
      end
      adsr_pkg::SQ_SQRT: begin
        alu_a = AW'(v_r);
        alu_b = AW'(root_try);
        if (alu_ge) begin
          v_nxt   = alu_diff[SW-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + NW'(1);
        c_nxt   = res_nxt[LW-1:0];
      end
      adsr_pkg::SQ_SCALE: begin
        mul_b = c_r;
        case (stage_r)
          adsr_pkg::ST_ATTACK: lvl_nxt = c_r;
          adsr_pkg::ST_DECAY: begin
            mul_a    = adsr_pkg::ONE_LVL - sus;
            prod_nxt = mul_prod;
          end
          adsr_pkg::ST_RELEASE: begin
            mul_a    = relf_r;
            prod_nxt = mul_prod;
          end
          default: lvl_nxt = '0;
        endcase
      end
      adsr_pkg::SQ_BLEND: begin
        alu_a   = (stage_r == adsr_pkg::ST_DECAY) ? AW'(adsr_pkg::ONE_LVL) : AW'(relf_r);
        alu_b   = AW'(prod_r >> FR);
        lvl_nxt = alu_diff[LW-1:0];
      end
      adsr_pkg::SQ_FINISH: begin
        if (out_free) begin
          level_nxt          = lvl_r;
          out_valid_nxt      = 1'b1;
          out_data_nxt.level = lvl_r;
          out_data_nxt.stage = stage_r;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      adsr_pkg::SQ_IDLE:   if (in_valid) seq_nxt = adsr_pkg::SQ_ELAPSE;
      adsr_pkg::SQ_ELAPSE: seq_nxt = adsr_pkg::SQ_CHECK;
      adsr_pkg::SQ_CHECK:  seq_nxt = adsr_pkg::SQ_PHASE;
      adsr_pkg::SQ_PHASE: begin
        if (stage_r == adsr_pkg::ST_SUSTAIN || stage_r == adsr_pkg::ST_OFF) begin
          seq_nxt = adsr_pkg::SQ_FINISH;
        end else if (alu_ge) begin
          seq_nxt = adsr_pkg::SQ_SHAPE;
        end else begin
          seq_nxt = adsr_pkg::SQ_DIV;
        end
      end
      adsr_pkg::SQ_DIV: begin
        if (cnt_r == NW'(adsr_pkg::DIV_STEPS - 1)) seq_nxt = adsr_pkg::SQ_SHAPE;
      end
      adsr_pkg::SQ_SHAPE: begin
        case (curve)
          adsr_pkg::CRV_SQUARE: seq_nxt = adsr_pkg::SQ_SQUARE;
          adsr_pkg::CRV_SQRT:   seq_nxt = adsr_pkg::SQ_SQRT;
          default:              seq_nxt = adsr_pkg::SQ_SCALE;
        endcase
      end
      adsr_pkg::SQ_SQUARE: seq_nxt = adsr_pkg::SQ_TAKE;
      adsr_pkg::SQ_TAKE:   seq_nxt = adsr_pkg::SQ_SCALE;
      adsr_pkg::SQ_SQRT: begin
        if (cnt_r == NW'(adsr_pkg::SQRT_STEPS - 1)) seq_nxt = adsr_pkg::SQ_SCALE;
      end
      adsr_pkg::SQ_SCALE: begin
        if (stage_r == adsr_pkg::ST_DECAY || stage_r == adsr_pkg::ST_RELEASE) begin
          seq_nxt = adsr_pkg::SQ_BLEND;
        end else begin
          seq_nxt = adsr_pkg::SQ_FINISH;
        end
      end
      adsr_pkg::SQ_BLEND:  seq_nxt = adsr_pkg::SQ_FINISH;
      adsr_pkg::SQ_FINISH: if (out_free) seq_nxt = adsr_pkg::SQ_IDLE;
      default:             seq_nxt = adsr_pkg::SQ_IDLE;
    endcase
  end

  // ports
  always_comb begin
    in_ready  = (seq_r == adsr_pkg::SQ_IDLE);
    out_valid = out_valid_r;
    out_data  = out_data_r;
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r           <= adsr_pkg::SQ_IDLE;
      stage_r         <= adsr_pkg::ST_OFF;
      start_r         <= '0;
      level_r         <= '0;
      relf_r          <= '0;
      out_valid_r     <= 1'b0;
      attack_ticks_r  <= adsr_pkg::RST_ATTACK_TICKS;
      decay_ticks_r   <= adsr_pkg::RST_DECAY_TICKS;
      sustain_level_r <= adsr_pkg::RST_SUSTAIN_LEVEL;
      release_ticks_r <= adsr_pkg::RST_RELEASE_TICKS;
      attack_curve_r  <= adsr_pkg::CRV_LINEAR;
      decay_curve_r   <= adsr_pkg::CRV_LINEAR;
      release_curve_r <= adsr_pkg::CRV_LINEAR;
    end else begin
      seq_r       <= seq_nxt;
      stage_r     <= stage_nxt;
      start_r     <= start_nxt;
      level_r     <= level_nxt;
      relf_r      <= relf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          adsr_pkg::CFG_ATTACK_TICKS:  attack_ticks_r  <= cfg_data[DW-1:0];
          adsr_pkg::CFG_DECAY_TICKS:   decay_ticks_r   <= cfg_data[DW-1:0];
          adsr_pkg::CFG_SUSTAIN_LEVEL: sustain_level_r <= cfg_data[LW-1:0];
          adsr_pkg::CFG_RELEASE_TICKS: release_ticks_r <= cfg_data[DW-1:0];
          adsr_pkg::CFG_ATTACK_CURVE:  attack_curve_r  <= cfg_data[CW-1:0];
          adsr_pkg::CFG_DECAY_CURVE:   decay_curve_r   <= cfg_data[CW-1:0];
          adsr_pkg::CFG_RELEASE_CURVE: release_curve_r <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    gate_r     <= gate_nxt;
    elapsed_r  <= elapsed_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    t_r        <= t_nxt;
    cnt_r      <= cnt_nxt;
    v_r        <= v_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
    prod_r     <= prod_nxt;
    c_r        <= c_nxt;
    lvl_r      <= lvl_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/adsr_alu.sv
module adsr_alu (
  input  logic [adsr_pkg::ALU_W-1:0] sub_a,
  input  logic [adsr_pkg::ALU_W-1:0] sub_b,
  output logic [adsr_pkg::ALU_W-1:0] sub_diff,
  output logic                       sub_ge,
  input  logic [adsr_pkg::LVL_W-1:0] mul_a,
  input  logic [adsr_pkg::LVL_W-1:0] mul_b,
  output logic [adsr_pkg::MUL_W-1:0] mul_prod
);

  logic borrow;

  // one subtractor serves elapsed time, compares, divide, root and blend steps
  assign {borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = ~borrow;

  assign mul_prod = adsr_pkg::MUL_W'(mul_a) * adsr_pkg::MUL_W'(mul_b);

endmodule

### rtl/adsr_checker.sv
module adsr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input adsr_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input adsr_pkg::out_item_t             out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // one request at a time: the port closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted request");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.level <= adsr_pkg::ONE_LVL)
    else $error("level above full scale");

  a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stage == adsr_pkg::ST_OFF |-> out_data.level == '0)
    else $error("nonzero level in off stage");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (.*);

### test/tb_adsr_envelope_generator.sv
`timescale 1ns / 100ps

module tb_adsr_envelope_generator;

  localparam int TIME_W     = adsr_pkg::TIME_W;
  localparam int LVL_W      = adsr_pkg::LVL_W;
  localparam int DUR_W      = adsr_pkg::DUR_W;
  localparam int CURVE_W    = adsr_pkg::CURVE_W;
  localparam int CFG_IDX_W  = adsr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = adsr_pkg::CFG_DATA_W;
  localparam int FRAC       = adsr_pkg::FRAC;

  localparam logic [LVL_W-1:0]   ONE_LVL   = adsr_pkg::ONE_LVL;
  localparam logic [CURVE_W-1:0] CRV_SPARE = 2'd3;

  typedef struct packed {
    logic                  is_cfg;
    logic [TIME_W-1:0]     note;
    logic                  gate;
    logic                  known;
    logic [LVL_W-1:0]      lvl;
    adsr_pkg::stage_t      stg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  adsr_pkg::in_item_t    in_data;
  logic                  out_valid;
  logic                  out_ready;
  adsr_pkg::out_item_t   out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // envelope state and register copies kept by the testbench
  adsr_pkg::stage_t   env_stage;
  logic [TIME_W-1:0]  env_start;
  logic [LVL_W-1:0]   env_level;
  logic [LVL_W-1:0]   env_rel_from;
  logic [DUR_W-1:0]   atk_ticks;
  logic [DUR_W-1:0]   dec_ticks;
  logic [DUR_W-1:0]   rel_ticks;
  logic [LVL_W-1:0]   sus_lvl;
  logic [CURVE_W-1:0] atk_curve;
  logic [CURVE_W-1:0] dec_curve;
  logic [CURVE_W-1:0] rel_curve;

  adsr_pkg::out_item_t pending_levels[$];
  script_row_t         script[$];
  int                  fail_count = 0;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  rx_hold_cycles = 0;
  logic [TIME_W-1:0]   clock_now;
  logic                gate_now;
  int                  gate_run;
  int                  step_max;

  adsr_envelope_generator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] ticks_or_one(input logic [DUR_W-1:0] ticks);
    return (ticks == '0) ? 64'd1 : 64'(ticks);
  endfunction

  function automatic logic [63:0] since_start(input logic [TIME_W-1:0] now);
    return (now >= env_start) ? 64'(now - env_start) : 64'd0;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // clamped phase of the current stage, bent by its curve
  function automatic logic [63:0] shaped_phase(input logic [TIME_W-1:0] now,
                                               input logic [DUR_W-1:0] ticks,
                                               input logic [CURVE_W-1:0] crv);
    logic [63:0] el;
    logic [63:0] dur;
    logic [63:0] t;
    el  = since_start(now);
    dur = ticks_or_one(ticks);
    t   = (el >= dur) ? 64'(ONE_LVL) : (el << FRAC) / dur;
    case (crv)
      adsr_pkg::CRV_SQUARE: return (t * t) >> FRAC;
      adsr_pkg::CRV_SQRT:   return floor_root(t << FRAC);
      default:              return t;
    endcase
  endfunction

  function automatic adsr_pkg::out_item_t step_envelope(input adsr_pkg::in_item_t req);
    logic [63:0]         sus;
    logic [63:0]         c;
    logic [63:0]         lvl;
    adsr_pkg::out_item_t res;
    sus = (sus_lvl > ONE_LVL) ? 64'(ONE_LVL) : 64'(sus_lvl);
    if (!req.gate && (env_stage == adsr_pkg::ST_ATTACK ||
                      env_stage == adsr_pkg::ST_DECAY ||
                      env_stage == adsr_pkg::ST_SUSTAIN)) begin
      env_stage    = adsr_pkg::ST_RELEASE;
      env_start    = req.note_time;
      env_rel_from = env_level;
    end else begin
      case (env_stage)
        adsr_pkg::ST_ATTACK: begin
          if (since_start(req.note_time) >= ticks_or_one(atk_ticks)) begin
            env_stage = adsr_pkg::ST_DECAY;
            env_start = req.note_time;
          end
        end
        adsr_pkg::ST_DECAY: begin
          // sustain keeps the decay start time
          if (since_start(req.note_time) >= ticks_or_one(dec_ticks))
            env_stage = adsr_pkg::ST_SUSTAIN;
        end
        adsr_pkg::ST_SUSTAIN: ;
        adsr_pkg::ST_RELEASE: begin
          if (req.gate) begin
            env_stage = adsr_pkg::ST_ATTACK;
            env_start = req.note_time;
          end else if (since_start(req.note_time) >= ticks_or_one(rel_ticks)) begin
            env_stage = adsr_pkg::ST_OFF;
          end
        end
        default: begin
          env_stage = adsr_pkg::ST_OFF;
          if (req.gate) begin
            env_stage = adsr_pkg::ST_ATTACK;
            env_start = req.note_time;
          end
        end
      endcase
    end
    case (env_stage)
      adsr_pkg::ST_ATTACK: lvl = shaped_phase(req.note_time, atk_ticks, atk_curve);
      adsr_pkg::ST_DECAY: begin
        c   = shaped_phase(req.note_time, dec_ticks, dec_curve);
        lvl = 64'(ONE_LVL) - (((64'(ONE_LVL) - sus) * c) >> FRAC);
      end
      adsr_pkg::ST_SUSTAIN: lvl = sus;
      adsr_pkg::ST_RELEASE: begin
        c   = shaped_phase(req.note_time, rel_ticks, rel_curve);
        lvl = 64'(env_rel_from) - ((64'(env_rel_from) * c) >> FRAC);
      end
      default: lvl = '0;
    endcase
    env_level = lvl[LVL_W-1:0];
    res.level = env_level;
    res.stage = env_stage;
    return res;
  endfunction

  function automatic script_row_t req_row(input logic [TIME_W-1:0] note, input logic gate);
    script_row_t r;
    r      = '0;
    r.note = note;
    r.gate = gate;
    return r;
  endfunction

  function automatic script_row_t req_known(input logic [TIME_W-1:0] note, input logic gate,
                                            input logic [LVL_W-1:0] lvl,
                                            input adsr_pkg::stage_t stg);
    script_row_t r;
    r       = req_row(note, gate);
    r.known = 1'b1;
    r.lvl   = lvl;
    r.stg   = stg;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return '1;
    if (r < 35) return CFG_DATA_W'($urandom_range(1, 8));
    return CFG_DATA_W'($urandom_range(1, 300));
  endfunction

  // leaves cfg_valid high so back-to-back writes keep it asserted
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      adsr_pkg::CFG_ATTACK_TICKS:  atk_ticks = data;
      adsr_pkg::CFG_DECAY_TICKS:   dec_ticks = data;
      adsr_pkg::CFG_SUSTAIN_LEVEL: sus_lvl   = data[LVL_W-1:0];
      adsr_pkg::CFG_RELEASE_TICKS: rel_ticks = data;
      adsr_pkg::CFG_ATTACK_CURVE:  atk_curve = data[CURVE_W-1:0];
      adsr_pkg::CFG_DECAY_CURVE:   dec_curve = data[CURVE_W-1:0];
      adsr_pkg::CFG_RELEASE_CURVE: rel_curve = data[CURVE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  task automatic send_request(input adsr_pkg::in_item_t req, input logic known,
                              input logic [LVL_W-1:0] lvl, input adsr_pkg::stage_t stg);
    adsr_pkg::out_item_t want;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    want = step_envelope(req);
    if (known) begin
      want.level = lvl;
      want.stage = stg;
    end
    pending_levels.push_back(want);
    @(negedge clk);
  endtask

  task automatic shuffle_settings();
    logic [LVL_W-1:0] sus;
    int r;
    wait_drained();
    r = $urandom_range(0, 99);
    if (r < 10) sus = LVL_W'($urandom_range(32769, 65535));
    else if (r < 20) sus = ONE_LVL;
    else if (r < 28) sus = '0;
    else sus = LVL_W'($urandom_range(0, 32768));
    write_reg(adsr_pkg::CFG_ATTACK_TICKS, random_ticks());
    write_reg(adsr_pkg::CFG_DECAY_TICKS, random_ticks());
    write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, {8'($urandom), sus});
    write_reg(adsr_pkg::CFG_RELEASE_TICKS, random_ticks());
    write_reg(adsr_pkg::CFG_ATTACK_CURVE, CFG_DATA_W'($urandom));
    write_reg(adsr_pkg::CFG_DECAY_CURVE, CFG_DATA_W'($urandom));
    write_reg(adsr_pkg::CFG_RELEASE_CURVE, CFG_DATA_W'($urandom));
    cfg_valid = 1'b0;
    step_max  = $urandom_range(1, 64);
  endtask

  // mostly held notes walking forward in time, some backward steps and wild jumps
  task automatic random_request();
    adsr_pkg::in_item_t req;
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      clock_now += TIME_W'($urandom_range(0, step_max));
      if (gate_run == 0) begin
        gate_now = !gate_now;
        gate_run = gate_now ? $urandom_range(1, 30) : $urandom_range(1, 10);
      end
      gate_run--;
    end else if (r < 91) begin
      clock_now -= TIME_W'($urandom_range(1, 100));
    end else begin
      clock_now = $urandom();
      gate_now  = 1'($urandom_range(0, 1));
    end
    req.note_time = clock_now;
    req.gate      = gate_now;
    send_request(req, 1'b0, '0, adsr_pkg::ST_OFF);
  endtask

  initial begin
    adsr_pkg::in_item_t req;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    clock_now = '0;
    gate_now  = 1'b0;
    gate_run  = 0;
    step_max  = 32;

    env_stage    = adsr_pkg::ST_OFF;
    env_start    = '0;
    env_level    = '0;
    env_rel_from = '0;
    atk_ticks    = adsr_pkg::RST_ATTACK_TICKS;
    dec_ticks    = adsr_pkg::RST_DECAY_TICKS;
    sus_lvl      = adsr_pkg::RST_SUSTAIN_LEVEL;
    rel_ticks    = adsr_pkg::RST_RELEASE_TICKS;
    atk_curve    = adsr_pkg::CRV_LINEAR;
    dec_curve    = adsr_pkg::CRV_LINEAR;
    rel_curve    = adsr_pkg::CRV_LINEAR;

    // full walk through the stages on reset settings
    script.push_back(req_known(32'd0, 1'b0, '0, adsr_pkg::ST_OFF));
    script.push_back(req_known(32'd100, 1'b1, '0, adsr_pkg::ST_ATTACK));
    script.push_back(req_row(32'd2500, 1'b1));
    script.push_back(req_known(32'd4900, 1'b1, ONE_LVL, adsr_pkg::ST_DECAY));
    script.push_back(req_row(32'd12100, 1'b1));
    script.push_back(req_known(32'd19300, 1'b1, adsr_pkg::RST_SUSTAIN_LEVEL,
                               adsr_pkg::ST_SUSTAIN));
    script.push_back(req_known(32'd19300, 1'b0, adsr_pkg::RST_SUSTAIN_LEVEL,
                               adsr_pkg::ST_RELEASE));
    script.push_back(req_row(32'd31300, 1'b0));
    script.push_back(req_row(32'd31300, 1'b1));
    // time running backwards holds elapsed at zero
    script.push_back(req_row(32'd31000, 1'b1));
    script.push_back(req_row(32'd33700, 1'b1));
    script.push_back(req_row(32'd33700, 1'b0));
    script.push_back(req_known(32'hFFFF_FFFF, 1'b0, '0, adsr_pkg::ST_OFF));
    // zero durations act as one tick, sustain above full scale clamps
    script.push_back(reg_row(adsr_pkg::CFG_ATTACK_TICKS, '0));
    script.push_back(reg_row(adsr_pkg::CFG_DECAY_TICKS, '0));
    script.push_back(reg_row(adsr_pkg::CFG_RELEASE_TICKS, '0));
    script.push_back(reg_row(adsr_pkg::CFG_SUSTAIN_LEVEL, '1));
    script.push_back(reg_row(adsr_pkg::CFG_ATTACK_CURVE, CFG_DATA_W'(adsr_pkg::CRV_SQUARE)));
    script.push_back(reg_row(adsr_pkg::CFG_DECAY_CURVE, CFG_DATA_W'(adsr_pkg::CRV_SQRT)));
    script.push_back(reg_row(adsr_pkg::CFG_RELEASE_CURVE, {22'h3F_FFFF, CRV_SPARE}));
    script.push_back(req_known(32'd5, 1'b1, '0, adsr_pkg::ST_ATTACK));
    script.push_back(req_known(32'd6, 1'b1, ONE_LVL, adsr_pkg::ST_DECAY));
    script.push_back(req_known(32'd7, 1'b1, ONE_LVL, adsr_pkg::ST_SUSTAIN));
    script.push_back(req_known(32'd7, 1'b0, ONE_LVL, adsr_pkg::ST_RELEASE));
    script.push_back(req_known(32'd8, 1'b0, '0, adsr_pkg::ST_OFF));
    // longest durations, zero sustain
    script.push_back(reg_row(adsr_pkg::CFG_ATTACK_TICKS, '1));
    script.push_back(reg_row(adsr_pkg::CFG_DECAY_TICKS, '1));
    script.push_back(reg_row(adsr_pkg::CFG_RELEASE_TICKS, '1));
    script.push_back(reg_row(adsr_pkg::CFG_SUSTAIN_LEVEL, '0));
    script.push_back(reg_row(adsr_pkg::CFG_ATTACK_CURVE, CFG_DATA_W'(adsr_pkg::CRV_SQRT)));
    script.push_back(reg_row(adsr_pkg::CFG_DECAY_CURVE, CFG_DATA_W'(adsr_pkg::CRV_SQUARE)));
    script.push_back(reg_row(adsr_pkg::CFG_RELEASE_CURVE, CFG_DATA_W'(adsr_pkg::CRV_SQRT)));
    script.push_back(req_known(32'd0, 1'b1, '0, adsr_pkg::ST_ATTACK));
    script.push_back(req_row(32'h0080_0000, 1'b1));
    script.push_back(req_known(32'h00FF_FFFF, 1'b1, ONE_LVL, adsr_pkg::ST_DECAY));
    script.push_back(req_row(32'h0180_0000, 1'b1));
    script.push_back(req_row(32'h0180_0000, 1'b0));
    script.push_back(req_row(32'h0200_0000, 1'b0));

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_drained();
        write_reg(script[i].idx, script[i].data);
      end else begin
        cfg_valid     = 1'b0;
        req.note_time = script[i].note;
        req.gate      = script[i].gate;
        send_request(req, script[i].known, script[i].lvl, script[i].stg);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 53; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 53; end
        default: begin tx_idle_pct = 25; rx_idle_pct = 25; end
      endcase
      for (int n = 0; n < 156; n++) begin
        if (n % 39 == 0) shuffle_settings();
        // stall the result side long enough to back up the input
        if (phase == 0 && n == 20) rx_hold_cycles = 300;
        if (phase == 1 && n == 90) wait_drained();
        random_request();
      end
    end

    wait_drained();
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending_levels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready = 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    adsr_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: level %0d stage %0d", out_data.level, out_data.stage);
      end else begin
        want = pending_levels.pop_front();
        if (out_data.level !== want.level || out_data.stage !== want.stage) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected level %0d stage %0d, got level %0d stage %0d",
                     want.level, want.stage, out_data.level, out_data.stage);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### adsr_envelope_generator.f
rtl/adsr_pkg.sv
rtl/adsr_alu.sv
rtl/adsr_envelope_generator.sv
rtl/adsr_checker.sv
test/tb_adsr_envelope_generator.sv
